@@ rtl/core/espg_pkg.sv @@
`default_nettype none
package espg_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int WIDTH_BITS_DEF   = 12;

  localparam int REG_BITS = 12;

  localparam logic [REG_BITS-1:0] MAX_WIDTH_RESET = 12'd1700;
  localparam logic [REG_BITS-1:0] MIN_WIDTH_RESET = 12'd40;
  localparam logic [REG_BITS-1:0] STEP_RESET      = 12'd100;
  localparam logic [REG_BITS-1:0] SLOT_LEN_RESET  = 12'd2500;

  // per-channel width after reset, in microseconds
  localparam int PULSE_WIDTH_RESET = 820;

  // 'A': first adjust letter
  localparam logic [7:0] FIRST_CMD = 8'd65;

  typedef enum logic [1:0] {
    REG_MAX_WIDTH = 2'd0,
    REG_MIN_WIDTH = 2'd1,
    REG_STEP      = 2'd2,
    REG_SLOT_LEN  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [REG_BITS-1:0] max_width;
    logic [REG_BITS-1:0] min_width;
    logic [REG_BITS-1:0] step;
  } limits_t;

endpackage
`default_nettype wire

@@ rtl/core/espg_lane.sv @@
`default_nettype none
// One channel's width register with its saturating adjust.
module espg_lane #(
  parameter int WIDTH_BITS = espg_pkg::WIDTH_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  upd,
  input  wire logic                  dec,
  input  wire espg_pkg::limits_t     limits,
  output logic      [WIDTH_BITS-1:0] width_next
);

  localparam int SUM_BITS =
      ((WIDTH_BITS > espg_pkg::REG_BITS) ? WIDTH_BITS : espg_pkg::REG_BITS) + 1;

  logic [WIDTH_BITS-1:0] width;
  logic [SUM_BITS-1:0]   w_ext;
  logic [SUM_BITS-1:0]   step_ext;
  logic [SUM_BITS-1:0]   max_ext;
  logic [SUM_BITS-1:0]   min_ext;
  logic [SUM_BITS-1:0]   sum;
  logic [SUM_BITS-1:0]   diff;
  logic [SUM_BITS-1:0]   adj;

  always_comb begin
    w_ext    = SUM_BITS'(width);
    step_ext = SUM_BITS'(limits.step);
    max_ext  = SUM_BITS'(limits.max_width);
    min_ext  = SUM_BITS'(limits.min_width);
    sum      = w_ext + step_ext;
    diff     = w_ext - step_ext;
    if (!dec) begin
      adj = (sum > max_ext) ? max_ext : sum;
    end else if (step_ext > w_ext || diff < min_ext) begin
      adj = min_ext;
    end else begin
      adj = diff;
    end
    width_next = upd ? WIDTH_BITS'(adj) : width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width <= WIDTH_BITS'(espg_pkg::PULSE_WIDTH_RESET);
    end else begin
      width <= width_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/eight_channel_servo_pulse_gen.sv @@
`default_nettype none
// Servo pulse generator: up to NUM_CHANNELS channel widths in microseconds.
// Input channel (in_valid/in_ready): func=1 is a one-microsecond tick that
// advances the slot counter; func=0 carries a command letter. 'A'+2c raises
// channel c by step_us (saturating at max), 'A'+2c+1 lowers it (saturating
// at min); other bytes change nothing. Every item gives exactly one result
// on the output channel (out_valid/out_ready): pin levels, active slot,
// hit flag and the addressed or active channel's width.
// An accepted item passes the input register, then the result register,
// before out_valid. Throughput: one item per cycle while the receiver
// does not stall; width update and slot counter sit in the second stage.
// A stalled receiver holds the result register; the input register takes
// one more item, then in_ready drops until out_ready returns.
// Config writes (cfg_we/cfg_index/cfg_data) take effect on the next edge.
// Synchronous reset: all widths 820, slot 0, counter 0, registers to their
// defaults (max 1700, min 40, step 100, slot length 2500), pipeline empty.
module eight_channel_servo_pulse_gen #(
  parameter int NUM_CHANNELS = espg_pkg::NUM_CHANNELS_DEF,
  parameter int WIDTH_BITS   = espg_pkg::WIDTH_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic [7:0]  command_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  pin_levels,
  output logic      [2:0]  active_slot,
  output logic             command_hit,
  output logic      [11:0] channel_width_us,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  localparam int SB = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int RB = espg_pkg::REG_BITS;

  // config registers
  logic [RB-1:0] max_width;
  logic [RB-1:0] min_width;
  logic [RB-1:0] step;
  logic [RB-1:0] slot_len;
  espg_pkg::limits_t limits;

  // slot timing state
  logic [SB-1:0] slot_index;
  logic [SB-1:0] slot_index_next;
  logic [RB-1:0] slot_elapsed;
  logic [RB-1:0] slot_elapsed_next;

  // input register
  logic       s1_valid;
  logic       s1_func;
  logic [7:0] s1_byte;

  logic stall;
  logic fire;

  logic       hit;
  logic [7:0] off;
  logic [6:0] ch;

  logic [WIDTH_BITS-1:0] width_next [NUM_CHANNELS];
  logic [WIDTH_BITS-1:0] width_sel;
  logic [7:0]            pins_next;

  logic [RB-1:0] len;
  logic [RB:0]   elapsed_inc;

  assign limits.max_width = max_width;
  assign limits.min_width = min_width;
  assign limits.step      = step;

  assign stall    = out_valid && !out_ready;
  assign fire     = s1_valid && !stall;
  assign in_ready = !s1_valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_width <= espg_pkg::MAX_WIDTH_RESET;
      min_width <= espg_pkg::MIN_WIDTH_RESET;
      step      <= espg_pkg::STEP_RESET;
      slot_len  <= espg_pkg::SLOT_LEN_RESET;
    end else if (cfg_we) begin
      case (espg_pkg::reg_idx_t'(cfg_index))
        espg_pkg::REG_MAX_WIDTH: max_width <= cfg_data;
        espg_pkg::REG_MIN_WIDTH: min_width <= cfg_data;
        espg_pkg::REG_STEP:      step      <= cfg_data;
        espg_pkg::REG_SLOT_LEN:  slot_len  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_func <= func;
      s1_byte <= command_byte;
    end
  end

  // command decode
  always_comb begin
    off = s1_byte - espg_pkg::FIRST_CMD;
    ch  = off[7:1];
    hit = !s1_func && (s1_byte >= espg_pkg::FIRST_CMD) &&
          ({1'b0, s1_byte} < (9'(espg_pkg::FIRST_CMD) + 9'(2 * NUM_CHANNELS)));
  end

  // slot counter; a slot length of zero behaves as one
  always_comb begin
    len = (slot_len == '0) ? RB'(1) : slot_len;
    elapsed_inc = {1'b0, slot_elapsed} + (RB+1)'(1);
    slot_index_next   = slot_index;
    slot_elapsed_next = slot_elapsed;
    if (fire && s1_func) begin
      if (elapsed_inc >= {1'b0, len}) begin
        slot_elapsed_next = '0;
        slot_index_next   = (slot_index == SB'(NUM_CHANNELS - 1)) ? '0 : slot_index + SB'(1);
      end else begin
        slot_elapsed_next = elapsed_inc[RB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_index   <= '0;
      slot_elapsed <= '0;
    end else begin
      slot_index   <= slot_index_next;
      slot_elapsed <= slot_elapsed_next;
    end
  end

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
    espg_lane #(
      .WIDTH_BITS(WIDTH_BITS)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .upd       (fire && hit && (ch == 7'(i))),
      .dec       (off[0]),
      .limits    (limits),
      .width_next(width_next[i])
    );
  end

  for (genvar i = 0; i < 8; i++) begin : g_pin
    if (i < NUM_CHANNELS) begin : g_on
      assign pins_next[i] = (slot_index_next == SB'(i)) &&
                            (32'(slot_elapsed_next) < 32'(width_next[i]));
    end else begin : g_off
      assign pins_next[i] = 1'b0;
    end
  end

  // one-hot select of the reported width: addressed channel on a hit,
  // active channel on a tick, nothing on a miss
  always_comb begin
    width_sel = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if ((s1_func && slot_index_next == SB'(i)) || (hit && ch == 7'(i))) begin
        width_sel = width_sel | width_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      pin_levels       <= pins_next;
      active_slot      <= 3'(slot_index_next);
      command_hit      <= hit;
      channel_width_us <= 12'(width_sel);
    end
  end

endmodule
`default_nettype wire

@@ test/testbench.sv @@
module testbench;

  localparam logic FUNC_CMD    = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;
  localparam int   CHANNELS    = 8;
  localparam int   HOLD_CYCLES = 80;
  localparam int   PHASES      = 10;

  typedef struct packed {
    logic [7:0]  pins;
    logic [2:0]  slot;
    logic        hit;
    logic [11:0] width;
  } servo_out_t;

  class servo_tracker;
    logic [11:0] max_w, min_w, step, slot_len;
    logic [11:0] widths [CHANNELS];
    logic [2:0]  slot;
    logic [11:0] elapsed;
    servo_out_t  expected_outputs[$];
    int          errors;

    function new();
      max_w    = espg_pkg::MAX_WIDTH_RESET;
      min_w    = espg_pkg::MIN_WIDTH_RESET;
      step     = espg_pkg::STEP_RESET;
      slot_len = espg_pkg::SLOT_LEN_RESET;
      foreach (widths[i]) widths[i] = 12'(espg_pkg::PULSE_WIDTH_RESET);
      slot    = '0;
      elapsed = '0;
      errors  = 0;
    endfunction

    function void set_reg(espg_pkg::reg_idx_t idx, logic [11:0] v);
      case (idx)
        espg_pkg::REG_MAX_WIDTH: max_w = v;
        espg_pkg::REG_MIN_WIDTH: min_w = v;
        espg_pkg::REG_STEP:      step = v;
        espg_pkg::REG_SLOT_LEN:  slot_len = v;
        default: ;
      endcase
    endfunction

    // advance the slot timer or apply an adjust letter, queue the output
    function void take_item(logic f, logic [7:0] b);
      servo_out_t  r;
      logic [11:0] len, w;
      logic [12:0] sum;
      int          ofs;
      r   = '0;
      ofs = int'(b) - int'(espg_pkg::FIRST_CMD);
      if (f == FUNC_TICK) begin
        len = (slot_len == 0) ? 12'd1 : slot_len;
        elapsed = elapsed + 12'd1;
        if (elapsed >= len) begin
          elapsed = '0;
          slot = slot + 3'd1;
        end
        r.width = widths[slot];
      end else if (ofs >= 0 && ofs < 2 * CHANNELS) begin
        w = widths[ofs / 2];
        if (ofs % 2 == 0) begin
          sum = {1'b0, w} + {1'b0, step};
          w = (sum > {1'b0, max_w}) ? max_w : sum[11:0];
        end else if (step > w || w - step < min_w) begin
          w = min_w;
        end else begin
          w = w - step;
        end
        widths[ofs / 2] = w;
        r.hit   = 1'b1;
        r.width = w;
      end
      r.slot = slot;
      if (elapsed < widths[slot]) r.pins = 8'd1 << slot;
      expected_outputs.push_back(r);
    endfunction

    task report(string what, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_output(servo_out_t got);
      servo_out_t want;
      if (expected_outputs.size() == 0) begin
        report("output with nothing outstanding, width", got.width, 0);
        return;
      end
      want = expected_outputs.pop_front();
      if (got.pins != want.pins) report("pin_levels", got.pins, want.pins);
      if (got.slot != want.slot) report("active_slot", got.slot, want.slot);
      if (got.hit != want.hit) report("command_hit", got.hit, want.hit);
      if (got.width != want.width) report("channel_width_us", got.width, want.width);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = FUNC_CMD;
  logic [7:0]  command_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  pin_levels;
  logic [2:0]  active_slot;
  logic        command_hit;
  logic [11:0] channel_width_us;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [11:0] cfg_data = 12'd0;

  bit gaps_on  = 1'b1;
  bit stall_on = 1'b1;
  bit hold_req = 1'b0;

  servo_tracker servo_model;

  eight_channel_servo_pulse_gen i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .command_byte(command_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .pin_levels(pin_levels), .active_slot(active_slot),
    .command_hit(command_hit), .channel_width_us(channel_width_us),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) servo_model.take_item(func, command_byte);
    if (!rst && out_valid && out_ready)
      servo_model.check_output(
        servo_out_t'{pin_levels, active_slot, command_hit, channel_width_us});
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int burst;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        burst = $urandom_range(1, 10);
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic f, logic [7:0] b);
    int gap;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    func         <= f;
    command_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random();
    int          pick;
    int          run;
    logic [7:0]  letter;
    pick = $urandom_range(0, 19);
    if (pick < 9) begin
      send_item(FUNC_TICK, 8'($urandom));
    end else if (pick < 16) begin
      send_item(FUNC_CMD,
                espg_pkg::FIRST_CMD + 8'($urandom_range(0, 2 * CHANNELS - 1)));
    end else if (pick < 18) begin
      // same letter repeated to drive a width into its limit
      letter = espg_pkg::FIRST_CMD + 8'($urandom_range(0, 2 * CHANNELS - 1));
      run = $urandom_range(4, 12);
      repeat (run) send_item(FUNC_CMD, letter);
    end else begin
      send_item(FUNC_CMD, 8'($urandom));
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (servo_model.expected_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(espg_pkg::reg_idx_t idx, logic [11:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    servo_model.set_reg(idx, v);
  endtask

  task automatic set_limits(logic [11:0] mx, logic [11:0] mn, logic [11:0] st,
                            logic [11:0] sl);
    write_cfg(espg_pkg::REG_MAX_WIDTH, mx);
    write_cfg(espg_pkg::REG_MIN_WIDTH, mn);
    write_cfg(espg_pkg::REG_STEP, st);
    write_cfg(espg_pkg::REG_SLOT_LEN, sl);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    servo_model = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every letter at reset limits, the bytes just outside, extremes, ticks
    for (int c = 0; c < CHANNELS; c++) begin
      send_item(FUNC_CMD, espg_pkg::FIRST_CMD + 8'(2 * c));
      send_item(FUNC_CMD, espg_pkg::FIRST_CMD + 8'(2 * c + 1));
    end
    send_item(FUNC_CMD, espg_pkg::FIRST_CMD - 8'd1);
    send_item(FUNC_CMD, espg_pkg::FIRST_CMD + 8'(2 * CHANNELS));
    send_item(FUNC_CMD, 8'h00);
    send_item(FUNC_CMD, 8'hFF);
    send_item(FUNC_TICK, 8'h00);
    send_item(FUNC_TICK, 8'hFF);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_limits(12'hFFF, 12'h000, 12'hFFF, 12'd1);
        1: set_limits(12'h000, 12'hFFF, 12'h000, 12'h000);  // crossed limits, zero slot
        2: set_limits(12'd1000, 12'd200, 12'd37, 12'd5);
        3: set_limits(12'd300, 12'd0, 12'd1, 12'd3);        // pulls wide channels down
        4: set_limits(12'($urandom_range(2000, 4095)), 12'($urandom_range(0, 500)),
                      12'd250, 12'hFFF);
        default: set_limits(12'($urandom), 12'($urandom), 12'($urandom_range(0, 600)),
                            12'($urandom_range(0, 12)));
      endcase
      if (p == PHASES - 1) begin
        gaps_on  = 1'b0;
        stall_on = 1'b0;
      end
      for (int n = 0; n < 60; n++) begin
        if (p == 5 && n == 10) hold_req = 1'b1;
        send_random();
      end
      drain();
    end

    repeat (6) @(posedge clk);
    if (servo_model.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
